### rtl/assert_macros.svh
// assertion macros used by the checker file e2q_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define AST_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked at every edge, reset included
`define AST_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### rtl/e2q_pkg.sv
// types, constants and helper functions for the euler to quaternion block
// no dependencies
package e2q_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int AtanTabLen = 24;
   localparam int AngW = 17;
   localparam int QuatW = 16;
   localparam int CodeW = 5;
   localparam int XyW = 34;
   localparam int ZW = 33;
   localparam int TrigW = 32;
   localparam int ProdW = 33;
   localparam int OpW = 34;
   localparam int MulW = 66;
   localparam int SumW = 67;

   localparam logic [32:0] AngScale = 33'd4797524520;
   localparam logic signed [XyW-1:0] CordicX0 = 34'sd652032874;
   localparam logic signed [17:0] QuarterTurn = 18'sd23040;
   localparam logic signed [17:0] HalfTurn = 18'sd46080;
   localparam logic signed [20:0] QuatMax = 21'sd16384;
   localparam logic signed [20:0] QuatMin = -21'sd16384;

   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   typedef struct packed {
      logic neg;
      logic flip;
   } fold_type;

   typedef struct packed {
      logic signed [XyW-1:0] x;
      logic signed [XyW-1:0] y;
      logic signed [ZW-1:0] z;
      fold_type fold;
   } cordic_type;

   typedef struct packed {
      logic rep;
      logic par;
      logic [1:0] ai;
      logic [1:0] aj;
      logic [1:0] ak;
   } order_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] r;
      case (idx)
         0: r = 33'sh03243F6A8;
         1: r = 33'sh01DAC6705;
         2: r = 33'sh00FADBAFC;
         3: r = 33'sh007F56EA6;
         4: r = 33'sh003FEAB76;
         5: r = 33'sh001FFD55B;
         6: r = 33'sh000FFFAAA;
         7: r = 33'sh0007FFF55;
         8: r = 33'sh0003FFFEA;
         9: r = 33'sh0001FFFFD;
         10: r = 33'sh0000FFFFF;
         11: r = 33'sh00007FFFF;
         12: r = 33'sh00003FFFF;
         13: r = 33'sh00001FFFF;
         14: r = 33'sh00000FFFF;
         15: r = 33'sh000007FFF;
         16: r = 33'sh000003FFF;
         17: r = 33'sh000001FFF;
         18: r = 33'sh000000FFF;
         19: r = 33'sh0000007FF;
         20: r = 33'sh0000003FF;
         21: r = 33'sh0000001FF;
         22: r = 33'sh0000000FF;
         23: r = 33'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] axis_next(input logic [2:0] idx);
      logic [1:0] r;
      case (idx)
         3'd0: r = AxisY;
         3'd1: r = AxisZ;
         3'd2: r = AxisX;
         3'd3: r = AxisY;
         default: r = AxisX;
      endcase
      return r;
   endfunction

   function automatic order_type decode_order(input logic [CodeW-1:0] code);
      order_type o;
      o.rep = code[1];
      o.par = code[2];
      o.ai = (code[4:3] == 2'd3) ? AxisX : code[4:3];
      o.aj = axis_next({1'b0, o.ai} + {2'b0, o.par});
      o.ak = axis_next({1'b0, o.ai} + 3'd1 - {2'b0, o.par});
      return o;
   endfunction

endpackage

### rtl/euler_to_quaternion.sv
// euler angle triple to unit quaternion, 24 conventions, pipelined cordic cells
// CORDIC_STAGES is capped at 24 cordic stages per lane
// one item per cycle while req_stall is low; throughput set by one cordic cell per stage per lane, three lanes
// synchronous active-high reset clears order_code, valid flags and the skid stage
// depends on e2q_pkg, e2q_trig_lane, e2q_combine
module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int CORDIC_STAGES = CordicStagesDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [CodeW-1:0]        csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [AngW-1:0]  req_angle_first,
   input  logic signed [AngW-1:0]  req_angle_second,
   input  logic signed [AngW-1:0]  req_angle_third,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [QuatW-1:0] rsp_quat_w,
   output logic signed [QuatW-1:0] rsp_quat_x,
   output logic signed [QuatW-1:0] rsp_quat_y,
   output logic signed [QuatW-1:0] rsp_quat_z
);

   localparam int NStages = (CORDIC_STAGES > AtanTabLen) ? AtanTabLen : CORDIC_STAGES;
   localparam int PipeLen = NStages + 6;

   typedef struct packed {
      logic signed [QuatW-1:0] w;
      logic signed [QuatW-1:0] x;
      logic signed [QuatW-1:0] y;
      logic signed [QuatW-1:0] z;
   } quat_type;

   logic [CodeW-1:0] order_code_ff;
   order_type order;
   logic adv, take, fresh;
   logic [PipeLen-1:0] valid_ff;
   logic signed [17:0] t1, t2, t3;
   logic signed [TrigW-1:0] ci, si, cj, sj, ch, sh;
   quat_type res, out_ff, skid_ff;
   logic out_valid_ff, skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_code_ff <= '0;
      end else if (csr_write_en) begin
         order_code_ff <= csr_write_data;
      end
   end

   assign order = decode_order(order_code_ff);
   assign adv = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // rotating frame swaps first and third, odd parity negates the middle angle
   always_comb begin
      t1 = order_code_ff[0] ? 18'(req_angle_third) : 18'(req_angle_first);
      t3 = order_code_ff[0] ? 18'(req_angle_first) : 18'(req_angle_third);
      t2 = order.par ? -18'(req_angle_second) : 18'(req_angle_second);
   end

   e2q_trig_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane_i (
      .clock(clock), .adv(adv), .angle(t1), .cos_out(ci), .sin_out(si)
   );
   e2q_trig_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane_j (
      .clock(clock), .adv(adv), .angle(t2), .cos_out(cj), .sin_out(sj)
   );
   e2q_trig_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane_h (
      .clock(clock), .adv(adv), .angle(t3), .cos_out(ch), .sin_out(sh)
   );

   e2q_combine u_combine (
      .clock  (clock),
      .adv    (adv),
      .order  (order),
      .ci     (ci),
      .si     (si),
      .cj     (cj),
      .sj     (sj),
      .ch     (ch),
      .sh     (sh),
      .quat_w (res.w),
      .quat_x (res.x),
      .quat_y (res.y),
      .quat_z (res.z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PipeLen-2:0], req_valid};
      end
   end

   assign take = out_valid_ff && !rsp_stall;
   assign fresh = adv && valid_ff[PipeLen-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (fresh) begin
         if (out_valid_ff && !take) begin
            skid_ff <= res;
            skid_valid_ff <= 1'b1;
         end else begin
            out_ff <= res;
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_quat_w = out_ff.w;
   assign rsp_quat_x = out_ff.x;
   assign rsp_quat_y = out_ff.y;
   assign rsp_quat_z = out_ff.z;

endmodule

### rtl/e2q_cordic_cell.sv
// one rotation-mode cordic cell, shift and arctangent fixed by its position
// depends on e2q_pkg
module e2q_cordic_cell
   import e2q_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       adv,
   input  cordic_type stage_prev,
   output cordic_type stage_out
);

   cordic_type stage_ff;
   cordic_type stage_in;

   always_comb begin
      stage_in.fold = stage_prev.fold;
      if (stage_prev.z >= 0) begin
         stage_in.x = stage_prev.x - (stage_prev.y >>> STAGE);
         stage_in.y = stage_prev.y + (stage_prev.x >>> STAGE);
         stage_in.z = stage_prev.z - atan_q30(STAGE);
      end else begin
         stage_in.x = stage_prev.x + (stage_prev.y >>> STAGE);
         stage_in.y = stage_prev.y - (stage_prev.x >>> STAGE);
         stage_in.z = stage_prev.z + atan_q30(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

### rtl/e2q_trig_lane.sv
// half-angle cosine and sine of one angle: fold, scale, cordic chain, unfold
// depends on e2q_pkg and e2q_cordic_cell
module e2q_trig_lane
   import e2q_pkg::*;
#(
   parameter int CORDIC_STAGES = CordicStagesDefault
) (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [17:0]      angle,
   output logic signed [TrigW-1:0] cos_out,
   output logic signed [TrigW-1:0] sin_out
);

   localparam int NStages = (CORDIC_STAGES > AtanTabLen) ? AtanTabLen : CORDIC_STAGES;

   logic signed [17:0] mag;
   logic signed [17:0] m_in, m_ff;
   fold_type fold_in, fold_ff, fold_z_ff;
   logic signed [51:0] scaled;
   logic signed [ZW-1:0] z_ff;
   cordic_type chain [0:NStages];
   logic signed [XyW-1:0] c_full, s_full;
   logic signed [TrigW-1:0] cos_ff, sin_ff;

   always_comb begin
      fold_in.neg = angle[17];
      mag = angle[17] ? -angle : angle;
      fold_in.flip = mag > QuarterTurn;
      m_in = fold_in.flip ? mag - HalfTurn : mag;
   end

   assign scaled = m_ff * $signed({1'b0, AngScale}) + 52'sd32768;

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
         fold_ff <= fold_in;
         z_ff <= scaled[48:16];
         fold_z_ff <= fold_ff;
      end
   end

   always_comb begin
      chain[0].x = CordicX0;
      chain[0].y = '0;
      chain[0].z = z_ff;
      chain[0].fold = fold_z_ff;
   end

   for (genvar g = 0; g < NStages; g++) begin : g_cell
      e2q_cordic_cell #(
         .STAGE(g)
      ) u_cell (
         .clock      (clock),
         .adv        (adv),
         .stage_prev (chain[g]),
         .stage_out  (chain[g+1])
      );
   end

   always_comb begin
      c_full = chain[NStages].fold.flip ? -chain[NStages].x : chain[NStages].x;
      s_full = (chain[NStages].fold.flip ^ chain[NStages].fold.neg)
               ? -chain[NStages].y : chain[NStages].y;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= c_full[TrigW-1:0];
         sin_ff <= s_full[TrigW-1:0];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

### rtl/e2q_combine.sv
// quaternion products from the three half-angle pairs, rounding and axis mapping
// depends on e2q_pkg
module e2q_combine
   import e2q_pkg::*;
(
   input  logic                    clock,
   input  logic                    adv,
   input  order_type               order,
   input  logic signed [TrigW-1:0] ci,
   input  logic signed [TrigW-1:0] si,
   input  logic signed [TrigW-1:0] cj,
   input  logic signed [TrigW-1:0] sj,
   input  logic signed [TrigW-1:0] ch,
   input  logic signed [TrigW-1:0] sh,
   output logic signed [QuatW-1:0] quat_w,
   output logic signed [QuatW-1:0] quat_x,
   output logic signed [QuatW-1:0] quat_y,
   output logic signed [QuatW-1:0] quat_z
);

   logic signed [63:0] p_cc, p_cs, p_sc, p_ss;
   logic signed [ProdW-1:0] cc_ff, cs_ff, sc_ff, ss_ff;
   logic signed [TrigW-1:0] cj1_ff, sj1_ff, cj2_ff, sj2_ff;
   logic signed [OpW-1:0] cc, cs, sc, ss;
   logic signed [OpW-1:0] op_in [0:3][0:1];
   logic signed [OpW-1:0] op_ff [0:3][0:1];
   logic signed [MulW-1:0] mul_ff [0:3][0:1];
   logic signed [SumW-1:0] sum [0:3];
   logic signed [SumW-1:0] rnd;
   logic signed [20:0] q [0:3];
   logic signed [QuatW-1:0] sat [0:3];
   logic signed [QuatW-1:0] axis_val [0:2];

   assign p_cc = ci * ch;
   assign p_cs = ci * sh;
   assign p_sc = si * ch;
   assign p_ss = si * sh;

   always_ff @(posedge clock) begin
      if (adv) begin
         cc_ff <= p_cc[62:30];
         cs_ff <= p_cs[62:30];
         sc_ff <= p_sc[62:30];
         ss_ff <= p_ss[62:30];
         cj1_ff <= cj;
         sj1_ff <= sj;
      end
   end

   // slot 0 multiplies by cj, slot 1 by sj; rows: w, ai, aj, ak
   always_comb begin
      cc = OpW'(cc_ff);
      cs = OpW'(cs_ff);
      sc = OpW'(sc_ff);
      ss = OpW'(ss_ff);
      if (order.rep) begin
         op_in[0][0] = cc - ss;
         op_in[0][1] = '0;
         op_in[1][0] = cs + sc;
         op_in[1][1] = '0;
         op_in[2][0] = '0;
         op_in[2][1] = cc + ss;
         op_in[3][0] = '0;
         op_in[3][1] = cs - sc;
      end else begin
         op_in[0][0] = cc;
         op_in[0][1] = ss;
         op_in[1][0] = sc;
         op_in[1][1] = -cs;
         op_in[2][0] = ss;
         op_in[2][1] = cc;
         op_in[3][0] = cs;
         op_in[3][1] = -sc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff <= op_in;
         cj2_ff <= cj1_ff;
         sj2_ff <= sj1_ff;
         for (int r = 0; r < 4; r++) begin
            mul_ff[r][0] <= op_ff[r][0] * cj2_ff;
            mul_ff[r][1] <= op_ff[r][1] * sj2_ff;
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum[r] = SumW'(mul_ff[r][0]) + SumW'(mul_ff[r][1]);
      end
      if (order.par) begin
         sum[2] = -sum[2];
      end
      for (int r = 0; r < 4; r++) begin
         rnd = sum[r] + (SumW'(1) <<< 45);
         q[r] = rnd[SumW-1:46];
         if (q[r] > QuatMax) begin
            sat[r] = QuatMax[QuatW-1:0];
         end else if (q[r] < QuatMin) begin
            sat[r] = QuatMin[QuatW-1:0];
         end else begin
            sat[r] = q[r][QuatW-1:0];
         end
      end
      for (int a = 0; a < 3; a++) begin
         if (order.ai == 2'(a)) begin
            axis_val[a] = sat[1];
         end else if (order.aj == 2'(a)) begin
            axis_val[a] = sat[2];
         end else begin
            axis_val[a] = sat[3];
         end
      end
   end

   assign quat_w = sat[0];
   assign quat_x = axis_val[0];
   assign quat_y = axis_val[1];
   assign quat_z = axis_val[2];

endmodule

### rtl/e2q_checker.sv
// port-level checks for euler_to_quaternion, bound to the top level
// depends on e2q_pkg and assert_macros.svh
`include "assert_macros.svh"

module e2q_checker
   import e2q_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [QuatW-1:0] rsp_quat_w,
   input logic signed [QuatW-1:0] rsp_quat_x,
   input logic signed [QuatW-1:0] rsp_quat_y,
   input logic signed [QuatW-1:0] rsp_quat_z
);

   localparam logic signed [QuatW-1:0] WMax = 16'sd16384;

   logic [4*QuatW-1:0] rsp_payload;

   assign rsp_payload = {rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z};

   `AST_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall)
   `AST_PROP(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `AST_PROP(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_payload))
   `AST_PROP(a_stall_needs_item, clock, reset, req_stall |-> rsp_valid)
   `AST_PROP(a_w_range, clock, reset, rsp_valid |-> rsp_quat_w <= WMax && rsp_quat_w >= -WMax)

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);

### tb/tb_euler_to_quaternion.sv
// testbench for euler_to_quaternion: directed and random angle triples under all conventions
// predicts each quaternion with its own cordic and product model; depends on e2q_pkg
`timescale 1ns / 100ps

module tb_euler_to_quaternion;
   import e2q_pkg::*;

   localparam int Stages = 16;
   localparam int Settle = Stages + 20;
   localparam longint Limit = 200000;
   localparam longint AngScaleQ = 64'sd4797524520;
   localparam longint InvGain = 64'sd652032874;
   localparam logic [CodeW-1:0] CodeMax = 5'd31;

   typedef struct {
      logic signed [QuatW-1:0] w;
      logic signed [QuatW-1:0] x;
      logic signed [QuatW-1:0] y;
      logic signed [QuatW-1:0] z;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CodeW-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [AngW-1:0] req_angle_first = '0;
   logic signed [AngW-1:0] req_angle_second = '0;
   logic signed [AngW-1:0] req_angle_third = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [QuatW-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   logic [CodeW-1:0] convention = '0;
   quat_type quat_pending[$];
   int fail_count = 0;
   longint cycle_count = 0;
   int stall_mode = 0;
   int stall_pct = 0;
   int burst_left = 0;

   longint atan_tab[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };
   logic [1:0] axis_after[4] = '{AxisY, AxisZ, AxisX, AxisY};

   euler_to_quaternion #(.CORDIC_STAGES(Stages)) u_dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_angle_first(req_angle_first), .req_angle_second(req_angle_second),
      .req_angle_third(req_angle_third),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // half angle cosine and sine in q30
   task automatic half_cos_sin(input longint h, output longint c, output longint s);
      longint m, x, y, z, nx;
      logic neg, flip;
      neg = h < 0;
      m = neg ? -h : h;
      flip = 1'b0;
      if (m > 23040) begin
         m = m - 46080;
         flip = 1'b1;
      end
      z = (m * AngScaleQ + 32768) >>> 16;
      x = InvGain;
      y = 0;
      for (int i = 0; i < Stages; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_tab[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_tab[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      if (neg) y = -y;
      c = x;
      s = y;
   endtask

   function automatic logic signed [QuatW-1:0] round_q14(input longint v);
      longint q;
      q = (v + (64'sd1 <<< 45)) >>> 46;
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return q[QuatW-1:0];
   endfunction

   task automatic predict_quat(input logic signed [AngW-1:0] a1, input logic signed [AngW-1:0] a2,
                               input logic signed [AngW-1:0] a3, output quat_type q);
      logic [1:0] ai, aj, ak;
      longint t1, t2, t3, ci, si, cj, sj, ch, sh, cc, cs, sc, ss, w;
      longint v[3];
      ai = (convention[4:3] == 2'd3) ? AxisX : convention[4:3];
      aj = axis_after[ai + convention[2]];
      ak = axis_after[ai + 1 - convention[2]];
      t1 = a1;
      t2 = a2;
      t3 = a3;
      if (convention[0]) begin
         t1 = a3;
         t3 = a1;
      end
      if (convention[2]) t2 = -t2;
      half_cos_sin(t1, ci, si);
      half_cos_sin(t2, cj, sj);
      half_cos_sin(t3, ch, sh);
      cc = (ci * ch) >>> 30;
      cs = (ci * sh) >>> 30;
      sc = (si * ch) >>> 30;
      ss = (si * sh) >>> 30;
      if (convention[1]) begin
         v[ai] = cj * (cs + sc);
         v[aj] = sj * (cc + ss);
         v[ak] = sj * (cs - sc);
         w = cj * (cc - ss);
      end else begin
         v[ai] = cj * sc - sj * cs;
         v[aj] = cj * ss + sj * cc;
         v[ak] = cj * cs - sj * sc;
         w = cj * cc + sj * ss;
      end
      if (convention[2]) v[aj] = -v[aj];
      q.w = round_q14(w);
      q.x = round_q14(v[0]);
      q.y = round_q14(v[1]);
      q.z = round_q14(v[2]);
   endtask

   // caller stands at a falling edge; returns at a falling edge
   task automatic send_angles(input logic signed [AngW-1:0] a1, input logic signed [AngW-1:0] a2,
                              input logic signed [AngW-1:0] a3);
      quat_type q;
      req_valid <= 1'b1;
      req_angle_first <= a1;
      req_angle_second <= a2;
      req_angle_third <= a3;
      do @(posedge clock); while (req_stall);
      predict_quat(a1, a2, a3, q);
      quat_pending.push_back(q);
      @(negedge clock);
   endtask

   // bursts of random length with random gaps
   task automatic send_paced(input logic signed [AngW-1:0] a1, input logic signed [AngW-1:0] a2,
                             input logic signed [AngW-1:0] a3);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      send_angles(a1, a2, a3);
   endtask

   function automatic logic signed [AngW-1:0] rand_angle();
      if ($urandom_range(0, 4) == 0) return AngW'($urandom_range(0, 131071));
      return AngW'($signed($urandom_range(0, 92160)) - 46080);
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (quat_pending.size() != 0) @(negedge clock);
      repeat (Settle) @(negedge clock);
   endtask

   task automatic write_convention(input logic [CodeW-1:0] code);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= code;
      @(negedge clock);
      csr_write_en <= 1'b0;
      convention = code;
   endtask

   task automatic test_reset_convention();
      send_angles(17'sd11520, 17'sd5760, -17'sd2880);
      send_angles('0, '0, '0);
   endtask

   task automatic test_extreme_angles();
      logic signed [AngW-1:0] edges[10] = '{
         17'sd46080, -17'sd46080, 17'sd23040, -17'sd23040, 17'sd23041,
         -17'sd23041, 17'sd65535, -17'sd65536, 17'sd46079, 17'sd1};
      write_convention(5'd0);
      foreach (edges[i]) send_angles(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]);
      write_convention(5'd23);
      foreach (edges[i]) send_angles(edges[(i + 5) % 10], edges[i], edges[(i + 1) % 10]);
   endtask

   task automatic test_all_conventions();
      for (int c = 0; c <= CodeMax; c++) begin
         write_convention(c[CodeW-1:0]);
         stall_mode = c % 3;
         repeat (12) send_paced(rand_angle(), rand_angle(), rand_angle());
      end
   endtask

   task automatic test_hold_until_empty();
      repeat (10) send_angles(rand_angle(), rand_angle(), rand_angle());
      req_valid <= 1'b0;
      while (quat_pending.size() != 0) @(negedge clock);
      repeat (10) send_angles(rand_angle(), rand_angle(), rand_angle());
   endtask

   task automatic test_random_mix();
      for (int p = 0; p < 6; p++) begin
         write_convention(CodeW'($urandom_range(0, 23)));
         stall_mode = p % 3;
         repeat (25) send_paced(rand_angle(), rand_angle(), rand_angle());
      end
   endtask

   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(10, 80);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         default: rsp_stall <= (cycle_count % 7) < 3;
      endcase
   end

   always @(posedge clock) begin
      quat_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count > Limit) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quat_pending.size() == 0) begin
            $display("%0t unexpected item w=%0d x=%0d y=%0d z=%0d", $time,
                     rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            fail_count++;
         end else begin
            e = quat_pending.pop_front();
            if (rsp_quat_w !== e.w || rsp_quat_x !== e.x ||
                rsp_quat_y !== e.y || rsp_quat_z !== e.z) begin
               $display("%0t mismatch expected w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                        $time, e.w, e.x, e.y, e.z,
                        rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_convention();
      test_extreme_angles();
      test_all_conventions();
      test_hold_until_empty();
      test_random_mix();
      drain();
      if (quat_pending.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
